FILE: design/avt_pkg.sv
// avt_pkg: shared widths, codes and controller/datapath bundles for the
// affine vertex transform. No dependencies; imported by every module of the block.
`default_nettype none

package avt_pkg;

   localparam int FRAC_BITS = 16;                   // Q16.16
   localparam int DATA_W    = 32;                   // matrix entry and vector component
   localparam int VEC_W     = DATA_W + 1;           // vector after v - t
   localparam int PROD_W    = DATA_W + VEC_W;       // one product
   localparam int ACC_W     = PROD_W + 3;           // three products plus translation
   localparam int RND_W     = ACC_W - FRAC_BITS;    // rounded dot product
   localparam int NUM_W     = 64;                   // divider dividend
   localparam int QUO_W     = 32;                   // quotient bits developed
   localparam int CNT_W     = $clog2(QUO_W);
   localparam int REQ_DATA_W = 136;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 2;

   typedef enum logic [2:0] {
      ACT_WRITE        = 3'd0,
      ACT_POINT        = 3'd1,
      ACT_ROTATE       = 3'd2,
      ACT_ROTATE_T     = 3'd3,
      ACT_INV_RIGID    = 3'd4,
      ACT_PROJECT      = 3'd5,
      ACT_PRETRANSLATE = 3'd6,
      ACT_UNUSED       = 3'd7
   } avt_action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_WZERO = 2'd1,
      STS_SAT   = 2'd2
   } avt_status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SUBT,
      OP_MUL,
      OP_ACC,
      OP_ADDT,
      OP_ROUND,
      OP_WSAVE,
      OP_NSAVE,
      OP_DIVSET,
      OP_DIVSTEP,
      OP_DIVEND,
      OP_PUBLISH
   } avt_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUBT,
      S_MUL,
      S_ACC,
      S_ADDT,
      S_ROUND,
      S_DIVSET,
      S_DIV,
      S_DIVEND,
      S_DONE
   } avt_state_type;

   typedef struct packed {
      avt_op_type  op;
      logic [1:0]  comp;   // output row being built (3 = w row)
      logic [1:0]  term;   // column within the dot product
   } avt_cmd_type;

   typedef struct packed {
      logic rnd_zero;      // rounded accumulator is zero
      logic out_free;      // response register can take a beat
   } avt_sts_type;

endpackage

`default_nettype wire

FILE: design/avt_ctrl.sv
// avt_ctrl: sequencer for the transform; issues one datapath command a cycle,
// holding in S_DONE while the response register is full. Depends on avt_pkg.
`default_nettype none

module avt_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire  [avt_pkg::REQ_USER_W-1:0] req_tuser,
   input  wire  avt_pkg::avt_sts_type    sts,
   output avt_pkg::avt_cmd_type          cmd
);
   import avt_pkg::*;

   avt_state_type  state_ff, state_in;
   avt_action_type action_ff, action_in;
   logic [1:0]       comp_ff, comp_in;
   logic [1:0]       term_ff, term_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             affine;
   avt_action_type   req_action;

   assign req_action = avt_action_type'(req_tuser);
   assign affine = (action_ff == ACT_POINT) || (action_ff == ACT_PROJECT)
                || (action_ff == ACT_PRETRANSLATE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         action_ff <= ACT_UNUSED;
         comp_ff   <= '0;
         term_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         action_ff <= action_in;
         comp_ff   <= comp_in;
         term_ff   <= term_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      comp_in    = comp_ff;
      term_in    = term_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.comp   = comp_ff;
      cmd.term   = term_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op    = OP_LOAD;
               action_in = req_action;
               comp_in   = (req_action == ACT_PROJECT) ? 2'd3 : 2'd0;
               term_in   = '0;
               case (req_action)
                  ACT_WRITE, ACT_UNUSED: state_in = S_DONE;
                  ACT_INV_RIGID:         state_in = S_SUBT;
                  default:               state_in = S_MUL;
               endcase
            end
         end
         S_SUBT: begin
            cmd.op = OP_SUBT;
            if (term_ff == 2'd2) begin
               term_in  = '0;
               state_in = S_MUL;
            end else begin
               term_in = term_ff + 2'd1;
            end
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (term_ff == 2'd2) begin
               term_in  = '0;
               state_in = affine ? S_ADDT : S_ROUND;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_ADDT: begin
            cmd.op   = OP_ADDT;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            if (action_ff == ACT_PROJECT) begin
               if (comp_ff == 2'd3) begin
                  cmd.op = OP_WSAVE;
                  if (sts.rnd_zero) begin
                     state_in = S_DONE;
                  end else begin
                     comp_in  = '0;
                     state_in = S_MUL;
                  end
               end else begin
                  cmd.op   = OP_NSAVE;
                  state_in = S_DIVSET;
               end
            end else begin
               cmd.op = OP_ROUND;
               if (comp_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_MUL;
               end
            end
         end
         S_DIVSET: begin
            cmd.op   = OP_DIVSET;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIVSTEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = S_DIVEND;
            end
         end
         S_DIVEND: begin
            cmd.op = OP_DIVEND;
            if (comp_ff == 2'd2) begin
               state_in = S_DONE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.op   = OP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/avt_datapath.sv
// avt_datapath: matrix store, multiply-accumulate, rounding, restoring divider
// and response register. Depends on avt_pkg; driven by avt_ctrl.
`default_nettype none

module avt_datapath (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  avt_pkg::avt_cmd_type     cmd,
   output avt_pkg::avt_sts_type           sts,
   input  wire  [avt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire  [avt_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [avt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [avt_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import avt_pkg::*;

   localparam logic signed [RND_W-1:0]  RND_MAX = RND_W'(64'sd2147483647);
   localparam logic signed [RND_W-1:0]  RND_MIN = -RND_MAX - RND_W'(1);
   localparam logic signed [ACC_W-1:0]  HALF    = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
   localparam logic signed [DATA_W-1:0] Q_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

   logic signed [DATA_W-1:0] mat_ff [16];
   logic signed [VEC_W-1:0]  vec_ff [3];
   logic signed [DATA_W-1:0] res_ff [3];
   avt_action_type           action_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [RND_W-1:0]  w_ff, n_ff;
   logic                     sat_ff, zw_ff;
   logic [RND_W-1:0]         mw_ff, rem_ff;
   logic [QUO_W-1:0]         quo_ff;
   logic                     neg_ff, big_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   avt_status_type           rsp_sts_ff;

   logic [3:0]               rd_addr;
   logic signed [DATA_W-1:0] mat_rd;
   logic                     transpose;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_half;
   logic signed [RND_W-1:0]  rnd;
   logic signed [DATA_W-1:0] rnd_sat;
   logic                     rnd_ovf;
   logic [RND_W-1:0]         mn, mw;
   logic [NUM_W-1:0]         num;
   logic [ACC_W-1:0]         mn_sh;
   logic                     big;
   logic [RND_W:0]           trial;
   logic                     fits;
   logic signed [DATA_W-1:0] q_res;
   logic                     q_ovf;
   avt_action_type           req_action;
   logic [1:0]               req_row, req_col;

   assign req_action = avt_action_type'(req_tuser);
   assign req_row    = req_tdata[1:0];
   assign req_col    = req_tdata[3:2];

   // single read port into the matrix
   assign transpose = (action_ff == ACT_ROTATE_T) || (action_ff == ACT_INV_RIGID);
   always_comb begin
      case (cmd.op)
         OP_SUBT: rd_addr = {cmd.term, 2'd3};
         OP_ADDT: rd_addr = {cmd.comp, 2'd3};
         default: rd_addr = transpose ? {cmd.term, cmd.comp} : {cmd.comp, cmd.term};
      endcase
   end
   assign mat_rd  = mat_ff[rd_addr];
   assign prod_in = mat_rd * vec_ff[cmd.term];

   // round half up, then clamp
   assign acc_half = acc_ff + HALF;
   assign rnd      = acc_half[ACC_W-1:FRAC_BITS];
   always_comb begin
      rnd_ovf = 1'b1;
      if (rnd > RND_MAX)      rnd_sat = Q_MAX;
      else if (rnd < RND_MIN) rnd_sat = Q_MIN;
      else begin
         rnd_sat = rnd[DATA_W-1:0];
         rnd_ovf = 1'b0;
      end
   end

   // divider set-up: |n| << F plus half the divisor
   assign mn    = n_ff[RND_W-1] ? RND_W'(-n_ff) : RND_W'(n_ff);
   assign mw    = w_ff[RND_W-1] ? RND_W'(-w_ff) : RND_W'(w_ff);
   assign mn_sh = {mn, {FRAC_BITS{1'b0}}};
   assign num   = mn_sh[NUM_W-1:0] + NUM_W'(mw >> 1);
   assign big   = (RND_W+QUO_W)'(num) >= {mw, {QUO_W{1'b0}}};
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign fits  = trial >= {1'b0, mw_ff};

   always_comb begin
      q_ovf = 1'b1;
      if (big_ff)                   q_res = neg_ff ? Q_MIN : Q_MAX;
      else if (!neg_ff) begin
         if (quo_ff[QUO_W-1])       q_res = Q_MAX;
         else begin
            q_res = quo_ff;
            q_ovf = 1'b0;
         end
      end else if (quo_ff > {1'b1, {(QUO_W-1){1'b0}}}) q_res = Q_MIN;
      else begin
         q_res = -quo_ff;
         q_ovf = 1'b0;
      end
   end

   // matrix store, identity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? ONE : '0;
         end
      end else if (cmd.op == OP_LOAD && req_action == ACT_WRITE) begin
         mat_ff[{req_row, req_col}] <= req_tdata[35:4];
      end else if (cmd.op == OP_ROUND && action_ff == ACT_PRETRANSLATE) begin
         mat_ff[{cmd.comp, 2'd3}] <= rnd_sat;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            action_ff <= req_action;
            vec_ff[0] <= VEC_W'($signed(req_tdata[67:36]));
            vec_ff[1] <= VEC_W'($signed(req_tdata[99:68]));
            vec_ff[2] <= VEC_W'($signed(req_tdata[131:100]));
            for (int i = 0; i < 3; i++) res_ff[i] <= '0;
            acc_ff <= '0;
            sat_ff <= 1'b0;
            zw_ff  <= 1'b0;
         end
         OP_SUBT:  vec_ff[cmd.term] <= vec_ff[cmd.term] - VEC_W'(mat_rd);
         OP_MUL:   prod_ff <= prod_in;
         OP_ACC:   acc_ff  <= acc_ff + ACC_W'(prod_ff);
         OP_ADDT:  acc_ff  <= acc_ff + (ACC_W'(mat_rd) <<< FRAC_BITS);
         OP_ROUND: begin
            res_ff[cmd.comp] <= rnd_sat;
            sat_ff <= sat_ff | rnd_ovf;
            acc_ff <= '0;
         end
         OP_WSAVE: begin
            w_ff   <= rnd;
            zw_ff  <= (rnd == '0);
            acc_ff <= '0;
         end
         OP_NSAVE: begin
            n_ff   <= rnd;
            acc_ff <= '0;
         end
         OP_DIVSET: begin
            mw_ff  <= mw;
            rem_ff <= RND_W'(num[NUM_W-1:QUO_W]);
            quo_ff <= num[QUO_W-1:0];
            neg_ff <= n_ff[RND_W-1] ^ w_ff[RND_W-1];
            big_ff <= big;
         end
         OP_DIVSTEP: begin
            rem_ff <= fits ? RND_W'(trial - {1'b0, mw_ff}) : RND_W'(trial);
            quo_ff <= {quo_ff[QUO_W-2:0], fits};
         end
         OP_DIVEND: begin
            res_ff[cmd.comp] <= q_res;
            sat_ff <= sat_ff | q_ovf;
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_PUBLISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUBLISH) begin
         rsp_x_ff   <= res_ff[0];
         rsp_y_ff   <= res_ff[1];
         rsp_z_ff   <= res_ff[2];
         rsp_sts_ff <= zw_ff ? STS_WZERO : (sat_ff ? STS_SAT : STS_OK);
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_z_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser    = rsp_sts_ff;
   assign sts.rnd_zero = (rnd == '0);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

FILE: design/affine_vertex_transform.sv
// affine_vertex_transform: 4x4 Q16.16 matrix applied to a 3-vector.
// Depends on avt_pkg, avt_ctrl and avt_datapath.
//
// channel  dir  handshake              payload
// req_     in   req_tvalid/req_tready  tuser: action; tdata: row, col, entry, x, y, z
// rsp_     out  rsp_tvalid/rsp_tready  tuser: status; tdata: x, y, z
//
// Items are handled one at a time, on the single shared multiplier and the one-bit
// restoring divider (32 divide steps per projective component). A projective item
// ends after the w row when w is 0. Requests are taken only between items.
// Reset (synchronous, high) loads the identity matrix and empties the response beat.
// A finished beat waits in the response register; the next request is taken while it
// waits, and the block stalls only when a new result finds that register still full.
`default_nettype none

module affine_vertex_transform (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // [1:0] row, [3:2] col, [35:4] entry_value, [67:36] vec_x,
   // [99:68] vec_y, [131:100] vec_z, [135:132] zero
   input  wire  [avt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] action
   input  wire  [avt_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // [31:0] out_x, [63:32] out_y, [95:64] out_z
   output logic [avt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [avt_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import avt_pkg::*;

   avt_cmd_type cmd;
   avt_sts_type sts;

   // sequencer: one command per cycle, waiting in S_DONE while the output is full
   avt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // matrix, MAC, divider and response register
   avt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: tb/affine_vertex_transform_test.sv
// affine_vertex_transform_test: self-checking bench for the 4x4 Q16.16 vertex transform.
// A local model of the matrix predicts each response beat; depends on avt_pkg and the RTL.
`default_nettype none

module affine_vertex_transform_test;
   timeunit 1ns;
   timeprecision 1ps;

   import avt_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [31:0] x, y, z;
      avt_status_type     sts;
   } vertex_beat_type;

   // Beats: req tdata = row, col, entry, x, y, z from bit 0 up; tuser = action.
   // rsp tdata = x, y, z; rsp tuser = status.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   affine_vertex_transform dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Local copy of the matrix, row-major, as signed 32-bit entries.
   logic signed [31:0] xform_matrix [16];
   vertex_beat_type    pending_vertices [$];
   int                 mismatches = 0;
   int                 beats_checked = 0;
   int                 action_count [8];
   int                 burst_left = 0;
   bit                 long_hold_req = 1'b0;
   int                 idle_cycles = 0;

   // ---------------------------------------------------------------- predictor
   function automatic wide_type round_q(wide_type acc);
      // divide by 2^16, nearest, ties toward +inf
      return (acc + (wide_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] clamp_q(wide_type v, ref bit sat);
      if (v > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Row r dotted with (v, 1), rounded, unclamped.
   function automatic wide_type affine_row(int r, wide_type v [3]);
      wide_type acc;
      acc = wide_type'(xform_matrix[r*4+3]) <<< FRAC_BITS;
      for (int c = 0; c < 3; c++) acc += wide_type'(xform_matrix[r*4+c]) * v[c];
      return round_q(acc);
   endfunction

   // Projective divide: 64-bit dividend wraps like the hardware's.
   function automatic wide_type project_div(wide_type n, wide_type w);
      logic [63:0] mn, mw, q;
      mn = (n < 0) ? 64'(-n) : 64'(n);
      mw = (w < 0) ? 64'(-w) : 64'(w);
      q  = ((mn << FRAC_BITS) + (mw >> 1)) / mw;
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
      return ((n < 0) != (w < 0)) ? -wide_type'(q) : wide_type'(q);
   endfunction

   function automatic vertex_beat_type transform_vertex(avt_action_type act, logic [1:0] row,
      logic [1:0] col, logic signed [31:0] entry, logic signed [31:0] vx,
      logic signed [31:0] vy, logic signed [31:0] vz);
      vertex_beat_type r;
      wide_type      v [3];
      wide_type      acc, w, m;
      logic signed [31:0] res [3];
      bit            sat;
      r.sts = STS_OK;
      sat = 1'b0;
      res = '{0, 0, 0};
      v[0] = vx; v[1] = vy; v[2] = vz;
      case (act)
         ACT_WRITE: xform_matrix[row*4+col] = entry;
         ACT_POINT, ACT_PRETRANSLATE: begin
            for (int i = 0; i < 3; i++) res[i] = clamp_q(affine_row(i, v), sat);
            if (act == ACT_PRETRANSLATE)
               for (int i = 0; i < 3; i++) xform_matrix[i*4+3] = res[i];
         end
         ACT_ROTATE, ACT_ROTATE_T, ACT_INV_RIGID: begin
            for (int i = 0; i < 3; i++) begin
               acc = 0;
               for (int j = 0; j < 3; j++) begin
                  m = (act == ACT_ROTATE) ? xform_matrix[i*4+j] : xform_matrix[j*4+i];
                  acc += m * v[j];
                  // inverse rigid subtracts the translation first
                  if (act == ACT_INV_RIGID) acc -= m * wide_type'(xform_matrix[j*4+3]);
               end
               res[i] = clamp_q(round_q(acc), sat);
            end
         end
         ACT_PROJECT: begin
            w = affine_row(3, v);
            if (w == 0) r.sts = STS_WZERO;
            else
               for (int i = 0; i < 3; i++)
                  res[i] = clamp_q(project_div(affine_row(i, v), w), sat);
         end
         default: ;
      endcase
      if (sat && r.sts == STS_OK) r.sts = STS_SAT;
      r.x = res[0]; r.y = res[1]; r.z = res[2];
      return r;
   endfunction

   // ---------------------------------------------------------------- sender
   task automatic send_beat(avt_action_type act, logic [1:0] row, logic [1:0] col,
      logic [31:0] entry, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      int gap;
      if (burst_left == 0) begin
         // between bursts drop valid for a random gap (sometimes none)
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = {4'b0, vz, vy, vx, entry, col, row};
      do @(posedge clock); while (!req_tready);
      pending_vertices.push_back(transform_vertex(act, row, col, entry, vx, vy, vz));
      action_count[act]++;
   endtask

   task automatic wait_drained();
      while (pending_vertices.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] q_small();
      // up to about +/-8.0 in Q16.16
      return $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h0008_0000))
                                  : -32'($urandom_range(0, 32'h0008_0000));
   endfunction

   function automatic logic [31:0] q_any();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         default: return q_small();
      endcase
   endfunction

   // ---------------------------------------------------------------- receiver
   initial begin
      int phase_mode, held;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            // long hold-off so the response register fills and req_tready drops
            rsp_tready = 1'b0;
            for (held = 0; held < 400; held++) @(negedge clock);
            long_hold_req = 1'b0;
         end
         if ($urandom_range(0, 63) == 0) phase_mode = $urandom_range(0, 3);
         case (phase_mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = $urandom_range(0, 1);
            2: rsp_tready = ($urandom_range(0, 7) != 0);
            default: rsp_tready = ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      vertex_beat_type exp_beat;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (pending_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected response beat %h", rsp_tdata);
         end else begin
            exp_beat = pending_vertices.pop_front();
            if (rsp_tdata[31:0] !== exp_beat.x || rsp_tdata[63:32] !== exp_beat.y ||
                rsp_tdata[95:64] !== exp_beat.z || rsp_tuser !== exp_beat.sts) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: beat %0d exp x=%h y=%h z=%h sts=%0d got x=%h y=%h z=%h sts=%0d",
                     beats_checked, exp_beat.x, exp_beat.y, exp_beat.z, exp_beat.sts,
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser);
            end
         end
      end
   end

   // watchdog: cycles with no beat moved on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("ERROR: no progress, %0d beats outstanding", pending_vertices.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   localparam logic [31:0] ONE = 32'h0001_0000;

   task automatic test_reset_identity();
      // identity after reset: point and projective return the vector; unused gives zeros
      send_beat(ACT_POINT, 0, 0, 0, 32'h0003_8000, 32'hfffe_0000, 32'h7fffffff);
      send_beat(ACT_PROJECT, 0, 0, 0, 32'h80000000, ONE, 32'h0000_0001);
      send_beat(ACT_UNUSED, 3, 3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
   endtask

   task automatic test_each_mode();
      // off-diagonal entries and translation, then every transform action
      send_beat(ACT_WRITE, 0, 1, 32'h0000_8000, 0, 0, 0);
      send_beat(ACT_WRITE, 1, 0, 32'hffff_8000, 0, 0, 0);
      send_beat(ACT_WRITE, 0, 3, 32'h0002_0000, 0, 0, 0);
      send_beat(ACT_WRITE, 2, 3, 32'hfffd_0000, 0, 0, 0);
      for (int a = ACT_POINT; a <= ACT_PROJECT; a++)
         send_beat(avt_action_type'(a), 0, 0, 0, 32'h0001_4000, 32'hfffe_c000, 32'h0000_0003);
      send_beat(ACT_PRETRANSLATE, 0, 0, 0, ONE, ONE, ONE);
      send_beat(ACT_INV_RIGID, 0, 0, 0, ONE, ONE, ONE);
   endtask

   task automatic test_saturation_and_wzero();
      // extreme entries force clamping; zero w row gives the w-zero status
      send_beat(ACT_WRITE, 0, 0, 32'h7fffffff, 0, 0, 0);
      send_beat(ACT_WRITE, 1, 1, 32'h80000000, 0, 0, 0);
      send_beat(ACT_POINT, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_beat(ACT_ROTATE_T, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff);
      send_beat(ACT_PROJECT, 0, 0, 0, 32'h7fffffff, 32'h80000000, ONE);
      send_beat(ACT_WRITE, 3, 3, 0, 0, 0, 0);
      send_beat(ACT_PROJECT, 0, 0, 0, ONE, ONE, ONE);
      send_beat(ACT_WRITE, 3, 2, 32'h0000_0001, 0, 0, 0);
      send_beat(ACT_PROJECT, 0, 0, 0, ONE, 32'h7fffffff, 32'h0000_0001);
      send_beat(ACT_PRETRANSLATE, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         send_beat(ACT_WRITE, 2'($urandom()), 2'($urandom()),
            ($urandom_range(0, 3) == 0) ? ONE : q_any(), $urandom(), $urandom(), $urandom());
      else if (pick < 38)
         send_beat(ACT_UNUSED, 2'($urandom()), 2'($urandom()), $urandom(), $urandom(),
            $urandom(), $urandom());
      else
         send_beat(avt_action_type'($urandom_range(ACT_POINT, ACT_PRETRANSLATE)),
            2'($urandom()), 2'($urandom()), $urandom(), q_any(), q_any(), q_any());
   endtask

   task automatic test_backpressure();
      long_hold_req = 1'b1;
      repeat (60) random_item();
   endtask

   task automatic test_random(int n);
      repeat (n) random_item();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_identity();
      test_each_mode();
      test_saturation_and_wzero();
      test_backpressure();
      test_random(1840);
      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      $display("Run covered %0d response beats: writes %0d, point %0d, rotate %0d, transposed %0d,",
         beats_checked, action_count[ACT_WRITE], action_count[ACT_POINT],
         action_count[ACT_ROTATE], action_count[ACT_ROTATE_T]);
      $display("  inverse rigid %0d, projective %0d, pretranslate %0d, unused %0d; %0d mismatches",
         action_count[ACT_INV_RIGID], action_count[ACT_PROJECT],
         action_count[ACT_PRETRANSLATE], action_count[ACT_UNUSED], mismatches);
      if (mismatches == 0 && pending_vertices.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      for (int i = 0; i < 16; i++) xform_matrix[i] = (i % 5 == 0) ? ONE : 32'sd0;
      for (int i = 0; i < 8; i++) action_count[i] = 0;
   end

endmodule

`default_nettype wire
